[design/led_cube_bam_frame_store_unit_macros.svh]
// Assertion helpers for the frame store.
`ifndef LED_CUBE_BAM_FRAME_STORE_UNIT_MACROS_SVH
`define LED_CUBE_BAM_FRAME_STORE_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define LCB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LCB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[design/lcb_pkg.sv]
`default_nettype none
package lcb_pkg;
    localparam int CUBE_ROWS = 8;
    localparam int CUBE_COLS = 8;
    localparam int CUBE_LAYERS = 8;
    localparam int PLANE_COUNT = 4;
    localparam int LEDS_PER_LAYER = CUBE_ROWS * CUBE_COLS;
    localparam int LED_TOTAL = LEDS_PER_LAYER * CUBE_LAYERS;
    localparam int USED_BITS = LEDS_PER_LAYER * 3;
    localparam int PLANE_BYTES = (USED_BITS + 7) / 8;
    localparam int STORE_BYTES = CUBE_LAYERS * PLANE_COUNT * PLANE_BYTES;
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int PB_W = $clog2(PLANE_BYTES + 1);
    localparam int PAD_BITS = USED_BITS % 8;
    localparam logic [7:0] PAD_KEEP = (PAD_BITS == 0) ? 8'hFF : 8'((1 << PAD_BITS) - 1);

    localparam logic [2:0] CMD_SET = 3'd0;
    localparam logic [2:0] CMD_READ = 3'd1;
    localparam logic [2:0] CMD_ON = 3'd2;
    localparam logic [2:0] CMD_OFF = 3'd3;
    localparam logic [2:0] CMD_COMMIT = 3'd4;
    localparam logic [2:0] CMD_SHIFT = 3'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;

    typedef struct packed {
        logic [2:0] command;
        logic [8:0] led_index;
        logic [3:0] red_level;
        logic [3:0] green_level;
        logic [3:0] blue_level;
        logic commit_now;
        logic [2:0] layer_select;
        logic [4:0] tick_count;
    } cmd_t;

    typedef struct packed {
        logic [11:0] pixel_value;
        logic [7:0] serial_byte;
        logic last_of_run;
        logic [1:0] status_code;
        logic dirty_flag;
    } res_t;

    // Address of byte b of a plane of a layer.
    function automatic logic [ADDR_W-1:0] plane_addr(input logic [2:0] layer,
                                                     input logic [1:0] plane,
                                                     input logic [ADDR_W-1:0] b);
        plane_addr = ADDR_W'((32'(layer) * PLANE_COUNT + 32'(plane)) * PLANE_BYTES) + b;
    endfunction
endpackage
`default_nettype wire

[design/lcb_cmd_if.sv]
`default_nettype none
interface lcb_cmd_if import lcb_pkg::*; ();
    logic valid;
    logic ready;
    cmd_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/lcb_res_if.sv]
`default_nettype none
interface lcb_res_if import lcb_pkg::*; ();
    logic valid;
    logic ready;
    res_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/lcb_plane_ram.sv]
`default_nettype none
module lcb_plane_ram import lcb_pkg::*; (
    input wire logic clk,
    input wire logic we,
    input wire logic [ADDR_W-1:0] waddr,
    input wire logic [7:0] wdata,
    input wire logic [ADDR_W-1:0] raddr,
    output logic [7:0] rdata
);
    logic [7:0] mem [STORE_BYTES];

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/led_cube_bam_frame_store_unit.sv]
`default_nettype none
// Channel   Dir  Contents
// cmd_in    in   command, index, levels, commit_now, layer, tick
// res_out   out  pixel_value, serial_byte, last_of_run, status_code, dirty_flag
// cfg       in   cfg_we, cfg_index, cfg_wdata (anode codes)
// After reset a clearing pass over all STORE_BYTES addresses (768) zeroes both buffers.
// Set rewrites 12 plane bits of the work buffer; read gathers 12 from the display buffer.
// Fill walks all STORE_BYTES addresses (768), commit copies them all, fill with commit both.
// Shift emits one byte per cycle when taken: PLANE_BYTES+1 results (25).
// A stalled shift byte is read again; while a result waits, the command side is not ready.
module led_cube_bam_frame_store_unit import lcb_pkg::*; (
    input wire logic clk,
    input wire logic rst_n,
    lcb_cmd_if.sink cmd_in,
    lcb_res_if.source res_out,
    input wire logic cfg_we,
    input wire logic [2:0] cfg_index,
    input wire logic [7:0] cfg_wdata
);
`include "led_cube_bam_frame_store_unit_macros.svh"

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RMW_RD, S_RMW_WAIT, S_RMW_WR, S_RD_RD, S_RD_WAIT,
        S_FILL, S_COPY, S_SHIFT, S_OUT
    } state_t;

    state_t state_reg;
    cmd_t cmd_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [3:0] step_reg;
    logic copy_wait_reg;
    logic dirty_reg;
    logic [11:0] pix_reg;
    logic [PB_W-1:0] sb_reg;
    logic [7:0] anode_reg [8];
    res_t res_reg;
    logic rvalid_reg;

    logic w_we, d_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr, d_waddr, d_raddr;
    logic [7:0] w_wdata, d_wdata, w_rdata, d_rdata;

    lcb_plane_ram u_work (.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata));
    lcb_plane_ram u_disp (.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata));

    // Address decode of the current pixel bit.
    logic [2:0] led_layer;
    logic [8:0] bitpos;
    logic [1:0] plane;
    logic [1:0] color;
    logic [ADDR_W-1:0] bit_addr;
    logic [2:0] bit_sh;
    logic led_ok;
    logic [1:0] tick_plane;
    logic [3:0] lvl;

    assign led_ok = 32'(cmd_reg.led_index) < LED_TOTAL;
    assign led_layer = 3'(32'(cmd_reg.led_index) / LEDS_PER_LAYER);
    assign color = step_reg[3:2];
    assign plane = step_reg[1:0];
    assign bitpos = 9'((32'(cmd_reg.led_index) % LEDS_PER_LAYER) * 3 + 32'(color));
    assign bit_addr = plane_addr(led_layer, plane, ADDR_W'(bitpos[8:3]));
    assign bit_sh = bitpos[2:0];
    assign tick_plane = cmd_reg.tick_count[3] ? 2'd3 : cmd_reg.tick_count[2] ? 2'd2 :
                        cmd_reg.tick_count[1] ? 2'd1 : 2'd0;
    always_comb
    begin
        case (color)
            2'd0: lvl = cmd_reg.red_level;
            2'd1: lvl = cmd_reg.green_level;
            default: lvl = cmd_reg.blue_level;
        endcase
    end

    // During a fill, sb_reg counts down the bytes left in the current plane.
    logic last_byte;
    assign last_byte = (sb_reg == PB_W'(1));

    // Memory port control.
    always_comb
    begin
        w_we = 1'b0;
        d_we = 1'b0;
        w_waddr = cnt_reg;
        d_waddr = cnt_reg;
        w_wdata = 8'h00;
        d_wdata = 8'h00;
        w_raddr = cnt_reg;
        d_raddr = cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                w_we = 1'b1;
                d_we = 1'b1;
            end
            S_RMW_RD, S_RMW_WAIT: w_raddr = bit_addr;
            S_RMW_WR:
            begin
                w_we = 1'b1;
                w_waddr = bit_addr;
                w_wdata = lvl[plane] ? (w_rdata | (8'h01 << bit_sh))
                                     : (w_rdata & ~(8'h01 << bit_sh));
            end
            S_RD_RD, S_RD_WAIT: d_raddr = bit_addr;
            S_FILL:
            begin
                w_we = 1'b1;
                w_wdata = (cmd_reg.command == CMD_ON) ? (last_byte ? PAD_KEEP : 8'hFF) : 8'h00;
            end
            S_COPY:
            begin
                d_we = copy_wait_reg;
                d_waddr = cnt_reg - ADDR_W'(1);
                d_wdata = w_rdata;
            end
            S_SHIFT: d_raddr = plane_addr(cmd_reg.layer_select, tick_plane,
                                          ADDR_W'(sb_reg - PB_W'(1)));
            default: ;
        endcase
    end

    assign cmd_in.ready = (state_reg == S_IDLE) && !rvalid_reg;
    assign res_out.valid = rvalid_reg;
    assign res_out.payload = res_reg;

    logic out_free;
    assign out_free = !rvalid_reg || res_out.ready;

    // Sequencer with the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cmd_reg <= '0;
            cnt_reg <= '0;
            step_reg <= '0;
            copy_wait_reg <= 1'b0;
            dirty_reg <= 1'b0;
            pix_reg <= '0;
            res_reg <= '0;
            rvalid_reg <= 1'b0;
            sb_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                anode_reg[i] <= 8'(1 << i);
            end
        end
        else
        begin
            if (cfg_we)
            begin
                anode_reg[cfg_index] <= cfg_wdata;
            end
            if (rvalid_reg && res_out.ready)
            begin
                rvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + ADDR_W'(1);
                    if (32'(cnt_reg) == STORE_BYTES - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (cmd_in.valid && !rvalid_reg)
                    begin
                        cmd_reg <= cmd_in.payload;
                        step_reg <= '0;
                        cnt_reg <= '0;
                        copy_wait_reg <= 1'b0;
                        pix_reg <= '0;
                        sb_reg <= PB_W'(PLANE_BYTES);
                        case (cmd_in.payload.command)
                            CMD_SET: state_reg <= S_RMW_RD;
                            CMD_READ: state_reg <= S_RD_RD;
                            CMD_ON, CMD_OFF: state_reg <= S_FILL;
                            CMD_COMMIT: state_reg <= S_COPY;
                            CMD_SHIFT: state_reg <= S_SHIFT;
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_RMW_RD:
                begin
                    if (!led_ok)
                    begin
                        res_reg <= '{12'd0, 8'd0, 1'b1, ST_RANGE, dirty_reg};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_RMW_WAIT;
                    end
                end
                S_RMW_WAIT: state_reg <= S_RMW_WR;
                S_RMW_WR:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd11)
                    begin
                        dirty_reg <= 1'b1;
                        res_reg <= '{12'd0, 8'd0, 1'b1, ST_OK, 1'b1};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_RMW_RD;
                    end
                end
                S_RD_RD:
                begin
                    if (!led_ok)
                    begin
                        res_reg <= '{12'd0, 8'd0, 1'b1, ST_RANGE, dirty_reg};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_RD_WAIT;
                    end
                end
                S_RD_WAIT:
                begin
                    pix_reg[step_reg] <= d_rdata[bit_sh];
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd11)
                    begin
                        res_reg <= '{pix_reg | (12'd1 << step_reg) & {12{d_rdata[bit_sh]}},
                                     8'd0, 1'b1, ST_OK, dirty_reg};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_RD_RD;
                    end
                end
                S_FILL:
                begin
                    cnt_reg <= cnt_reg + ADDR_W'(1);
                    sb_reg <= last_byte ? PB_W'(PLANE_BYTES) : sb_reg - PB_W'(1);
                    if (32'(cnt_reg) == STORE_BYTES - 1)
                    begin
                        cnt_reg <= '0;
                        if (cmd_reg.commit_now)
                        begin
                            state_reg <= S_COPY;
                        end
                        else
                        begin
                            dirty_reg <= 1'b1;
                            res_reg <= '{12'd0, 8'd0, 1'b1, ST_OK, 1'b1};
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_COPY:
                begin
                    copy_wait_reg <= 1'b1;
                    cnt_reg <= cnt_reg + ADDR_W'(1);
                    if (copy_wait_reg && 32'(cnt_reg) == STORE_BYTES)
                    begin
                        dirty_reg <= 1'b0;
                        res_reg <= '{12'd0, 8'd0, 1'b1, ST_OK, 1'b0};
                        state_reg <= S_OUT;
                    end
                end
                S_SHIFT:
                begin
                    if (cmd_reg.tick_count[4])
                    begin
                        res_reg <= '{12'd0, 8'd0, 1'b1, ST_TICK, dirty_reg};
                        state_reg <= S_OUT;
                    end
                    else if (32'(cmd_reg.layer_select) >= CUBE_LAYERS)
                    begin
                        res_reg <= '{12'd0, 8'd0, 1'b1, ST_RANGE, dirty_reg};
                        state_reg <= S_OUT;
                    end
                    else if (out_free)
                    begin
                        if (sb_reg == '0)
                        begin
                            // Byte 0 goes out; the anode byte follows from S_OUT.
                            res_reg <= '{12'd0, d_rdata, 1'b0, ST_OK, dirty_reg};
                            rvalid_reg <= 1'b1;
                            state_reg <= S_OUT;
                            copy_wait_reg <= 1'b0;
                        end
                        else
                        begin
                            // Pipelined read: the byte requested last cycle is sent now.
                            if (copy_wait_reg)
                            begin
                                res_reg <= '{12'd0, d_rdata, 1'b0, ST_OK, dirty_reg};
                                rvalid_reg <= 1'b1;
                            end
                            copy_wait_reg <= 1'b1;
                            sb_reg <= sb_reg - PB_W'(1);
                        end
                    end
                    else
                    begin
                        // Stalled: step back so that the held byte is read again.
                        if (copy_wait_reg)
                        begin
                            sb_reg <= sb_reg + PB_W'(1);
                        end
                        copy_wait_reg <= 1'b0;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        if (cmd_reg.command == CMD_SHIFT && sb_reg == '0
                            && !cmd_reg.tick_count[4]
                            && 32'(cmd_reg.layer_select) < CUBE_LAYERS)
                        begin
                            res_reg <= '{12'd0, anode_reg[cmd_reg.layer_select], 1'b1,
                                         ST_OK, dirty_reg};
                        end
                        state_reg <= S_IDLE;
                        rvalid_reg <= 1'b1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `LCB_ASSERT_IMP(a_ready_idle, cmd_in.ready, !rvalid_reg || state_reg == S_IDLE)
    `LCB_ASSERT_NXT(a_accept_leaves_idle, cmd_in.valid && cmd_in.ready && cmd_in.payload.command <= CMD_SHIFT, !cmd_in.ready)
    `LCB_ASSERT_IMP(a_commit_clean, rvalid_reg && res_reg.last_of_run && cmd_reg.command == CMD_COMMIT, !res_reg.dirty_flag)
endmodule
`default_nettype wire

[dv/tb_led_cube_bam_frame_store_unit.sv]
`default_nettype none
module tb_led_cube_bam_frame_store_unit;
    import lcb_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] CMD_BAD6 = 3'd6;
    localparam logic [2:0] CMD_BAD7 = 3'd7;

    // Predicts the results of the frame store and checks the ones it produces.
    class frame_scoreboard;
        logic [7:0] work_mem [STORE_BYTES];
        logic [7:0] show_mem [STORE_BYTES];
        logic dirty;
        logic [7:0] anode [8];
        res_t pending [$];
        int errors;

        function void clear();
            for (int i = 0; i < STORE_BYTES; i++)
            begin
                work_mem[i] = '0;
                show_mem[i] = '0;
            end
            dirty = 1'b0;
            for (int i = 0; i < 8; i++)
                anode[i] = 8'(1 << i);
            pending.delete();
            errors = 0;
        endfunction

        function int base_of(int layer, int plane);
            return (layer * PLANE_COUNT + plane) * PLANE_BYTES;
        endfunction

        function void push(logic [11:0] pix, logic [7:0] b, logic last, logic [1:0] st);
            res_t r;
            r.pixel_value = pix;
            r.serial_byte = b;
            r.last_of_run = last;
            r.status_code = st;
            r.dirty_flag = dirty;
            pending.push_back(r);
        endfunction

        function void note_command(cmd_t c);
            int layer;
            int bitpos;
            int addr;
            int plane;
            logic [11:0] pix;
            logic [3:0] lvl;
            layer = int'(c.led_index) / LEDS_PER_LAYER;
            bitpos = (int'(c.led_index) % LEDS_PER_LAYER) * 3;
            case (c.command)
                CMD_SET:
                begin
                    if (c.led_index >= LED_TOTAL)
                        push('0, '0, 1'b1, ST_RANGE);
                    else
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            lvl = (k == 0) ? c.red_level : (k == 1) ? c.green_level : c.blue_level;
                            for (int p = 0; p < PLANE_COUNT; p++)
                            begin
                                addr = base_of(layer, p) + (bitpos + k) / 8;
                                work_mem[addr][(bitpos + k) % 8] = lvl[p];
                            end
                        end
                        dirty = 1'b1;
                        push('0, '0, 1'b1, ST_OK);
                    end
                end
                CMD_READ:
                begin
                    if (c.led_index >= LED_TOTAL)
                        push('0, '0, 1'b1, ST_RANGE);
                    else
                    begin
                        pix = '0;
                        for (int k = 0; k < 3; k++)
                            for (int p = 0; p < PLANE_COUNT; p++)
                            begin
                                addr = base_of(layer, p) + (bitpos + k) / 8;
                                pix[k * 4 + p] = show_mem[addr][(bitpos + k) % 8];
                            end
                        push(pix, '0, 1'b1, ST_OK);
                    end
                end
                CMD_ON, CMD_OFF:
                begin
                    for (int i = 0; i < STORE_BYTES; i++)
                        work_mem[i] = (c.command == CMD_ON) ? 8'hFF : 8'h00;
                    if (c.command == CMD_ON)
                        for (int l = 0; l < CUBE_LAYERS; l++)
                            for (int p = 0; p < PLANE_COUNT; p++)
                                work_mem[base_of(l, p) + PLANE_BYTES - 1] &= PAD_KEEP;
                    dirty = 1'b1;
                    if (c.commit_now)
                    begin
                        show_mem = work_mem;
                        dirty = 1'b0;
                    end
                    push('0, '0, 1'b1, ST_OK);
                end
                CMD_COMMIT:
                begin
                    show_mem = work_mem;
                    dirty = 1'b0;
                    push('0, '0, 1'b1, ST_OK);
                end
                CMD_SHIFT:
                begin
                    if (c.tick_count > 15)
                        push('0, '0, 1'b1, ST_TICK);
                    else if (c.layer_select >= CUBE_LAYERS)
                        push('0, '0, 1'b1, ST_RANGE);
                    else
                    begin
                        plane = (c.tick_count >= 8) ? 3 : (c.tick_count >= 4) ? 2 :
                                (c.tick_count >= 2) ? 1 : 0;
                        for (int i = PLANE_BYTES - 1; i >= 0; i--)
                            push('0, show_mem[base_of(c.layer_select, plane) + i], 1'b0, ST_OK);
                        push('0, anode[c.layer_select], 1'b1, ST_OK);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(res_t got);
            res_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.pixel_value !== exp_r.pixel_value)
                $display("%0t: pixel_value expected %h actual %h", $time,
                         exp_r.pixel_value, got.pixel_value);
            if (got.serial_byte !== exp_r.serial_byte)
                $display("%0t: serial_byte expected %h actual %h", $time,
                         exp_r.serial_byte, got.serial_byte);
            if (got.last_of_run !== exp_r.last_of_run)
                $display("%0t: last_of_run expected %b actual %b", $time,
                         exp_r.last_of_run, got.last_of_run);
            if (got.status_code !== exp_r.status_code)
                $display("%0t: status_code expected %0d actual %0d", $time,
                         exp_r.status_code, got.status_code);
            if (got.dirty_flag !== exp_r.dirty_flag)
                $display("%0t: dirty_flag expected %b actual %b", $time,
                         exp_r.dirty_flag, got.dirty_flag);
            if (got !== exp_r)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_wdata;
    int idle_cycles;
    frame_scoreboard board;

    lcb_cmd_if cmd_bus ();
    lcb_res_if res_bus ();

    led_cube_bam_frame_store_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_in(cmd_bus.sink),
        .res_out(res_bus.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: random stalls, check each transaction.
    initial
    begin
        int stall;
        res_bus.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (res_bus.valid && res_bus.ready)
                board.check_result(res_bus.payload);
            stall = gap_len();
            if (stall > 0 && res_bus.ready)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall - 1) @(posedge clk);
                @(posedge clk);
                res_bus.ready <= 1'b1;
            end
            else
                res_bus.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Valid stays high into the next transaction when there is no gap.
    task automatic send_cmd(cmd_t c);
        int gap;
        cmd_bus.valid <= 1'b1;
        cmd_bus.payload <= c;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        board.note_command(c);
        gap = gap_len();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        cmd_bus.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_anode(int idx, logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_index <= 3'(idx);
        cfg_wdata <= value;
        @(posedge clk);
        board.anode[idx] = value;
    endtask

    function automatic cmd_t make_cmd(logic [2:0] op);
        cmd_t c;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        c = raw[$bits(cmd_t)-1:0];
        c.command = op;
        return c;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            c = make_cmd(CMD_SET);
        else if (r < 60)
            c = make_cmd(CMD_READ);
        else if (r < 85)
            c = make_cmd(CMD_SHIFT);
        else if (r < 89)
            c = make_cmd(CMD_COMMIT);
        else if (r < 91)
            c = make_cmd(CMD_ON);
        else if (r < 93)
            c = make_cmd(CMD_OFF);
        else
            c = make_cmd($urandom_range(0, 1) ? CMD_BAD6 : CMD_BAD7);
        // Most ticks in range (indexes and layers always are) so that data paths get exercised.
        if (c.command == CMD_SHIFT && $urandom_range(0, 9) != 0)
            c.tick_count[4] = 1'b0;
        return c;
    endfunction

    initial
    begin
        cmd_t c;
        board = new();
        board.clear();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.payload = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes, every command and the special cases.
        c = make_cmd(CMD_SET); c.led_index = 9'd0; c.red_level = 4'hF;
        c.green_level = 4'h0; c.blue_level = 4'hF; send_cmd(c);
        c = make_cmd(CMD_SET); c.led_index = 9'd511; c.red_level = 4'h0;
        c.green_level = 4'hF; c.blue_level = 4'h5; send_cmd(c);
        c = make_cmd(CMD_READ); c.led_index = 9'd0; send_cmd(c);
        c = make_cmd(CMD_COMMIT); send_cmd(c);
        c = make_cmd(CMD_READ); c.led_index = 9'd0; send_cmd(c);
        c = make_cmd(CMD_READ); c.led_index = 9'd511; send_cmd(c);
        for (int t = 0; t < 16; t += 5)
        begin
            c = make_cmd(CMD_SHIFT); c.tick_count = 5'(t); c.layer_select = 3'd7;
            send_cmd(c);
        end
        c = make_cmd(CMD_SHIFT); c.tick_count = 5'd31; send_cmd(c);
        c = make_cmd(CMD_SHIFT); c.tick_count = 5'd16; c.layer_select = 3'd0; send_cmd(c);
        c = make_cmd(CMD_ON); c.commit_now = 1'b0; send_cmd(c);
        c = make_cmd(CMD_SHIFT); c.tick_count = 5'd15; c.layer_select = 3'd0; send_cmd(c);
        c = make_cmd(CMD_ON); c.commit_now = 1'b1; send_cmd(c);
        c = make_cmd(CMD_SHIFT); c.tick_count = 5'd0; c.layer_select = 3'd3; send_cmd(c);
        c = make_cmd(CMD_READ); c.led_index = 9'd200; send_cmd(c);
        c = make_cmd(CMD_BAD6); send_cmd(c);
        c = make_cmd(CMD_BAD7); send_cmd(c);
        c = make_cmd(CMD_OFF); c.commit_now = 1'b1; send_cmd(c);
        c = make_cmd(CMD_OFF); c.commit_now = 1'b0; send_cmd(c);
        drain();

        // Register extremes, then random settings between phases.
        for (int i = 0; i < 8; i++)
            write_anode(i, (i % 2) ? 8'hFF : 8'h00);
        cfg_we <= 1'b0;
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int n = 0; n < 105; n++)
                send_cmd(random_cmd());
            drain();
            for (int i = 0; i < 8; i++)
                write_anode(i, 8'($urandom));
            cfg_we <= 1'b0;
        end
        c = make_cmd(CMD_SHIFT); c.tick_count = 5'd9; c.layer_select = 3'd5; send_cmd(c);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire
